>>> design/mpba_pkg.sv
package mpba_pkg;

  localparam int MAX_POOLS_DEF   = 8;
  localparam int ARENA_LINKS_DEF = 8192;

  localparam logic [16:0] ARENA_MAX   = 17'd65536;
  localparam logic [3:0]  ALIGN_MAX   = 4'd8;
  localparam logic [9:0]  LINK_ROOM   = 10'd8;

  localparam logic [16:0] ARENA_RESET = 17'd65536;
  localparam logic [3:0]  ALIGN_RESET = 4'd3;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2
  } cmd_t;

  localparam logic REG_ARENA = 1'b0;
  localparam logic REG_ALIGN = 1'b1;

  typedef struct packed {
    logic [16:0] arena_bytes;
    logic [3:0]  align_log2;
  } cfg_t;

endpackage

>>> design/multi_pool_block_allocator_core.sv
// allocate and free: the link store read is registered as the item is taken, and the
// result register is loaded in the execute state once the output is free; no new item is taken until then
// create writes one link per block in the walk state, then posts a successful result
// from the finish state once the output is free
// reset clears pool valid bits, the arena bump pointer and the config registers;
// the link store is not cleared and entries are defined only once written
module multi_pool_block_allocator_core #(
  parameter int MAX_POOLS   = mpba_pkg::MAX_POOLS_DEF,
  parameter int ARENA_LINKS = mpba_pkg::ARENA_LINKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_pool_index,
  input  logic [15:0] in_region_bytes,
  input  logic [15:0] in_slug_bytes,
  input  logic [15:0] in_free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [15:0] out_block_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpba_pkg::*;

  localparam int PW = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_FIN} state_t;

  state_t state_r, state_nxt;
  cfg_t   cfg;

  // captured item
  logic [1:0]  cmd_r;
  logic [3:0]  pidx_r;
  logic [15:0] region_r, slug_r, faddr_r;

  // pool descriptor table
  logic        valid_r     [MAX_POOLS];
  logic [15:0] start_r     [MAX_POOLS];
  logic [16:0] region_tab_r[MAX_POOLS];
  logic [16:0] block_tab_r [MAX_POOLS];
  logic [15:0] slug_tab_r  [MAX_POOLS];
  logic [16:0] inuse_r     [MAX_POOLS];
  logic [15:0] head_r      [MAX_POOLS];
  logic [16:0] arena_used_r;

  // create walk
  logic [15:0] walk_start_r;
  logic [16:0] walk_off_r, walk_block_r, walk_size_r;

  // result register
  logic        out_valid_r, out_ok_r;
  logic [15:0] out_addr_r;

  logic        accept, out_free, load_out;
  logic        in_hit, pool_hit;
  logic [PW-1:0] in_sel, sel;
  logic [15:0] rd_data, wr_addr, wr_data;
  logic        wr_en;

  // derived create values
  logic [3:0]  sh;
  logic [8:0]  a_val, a_mask, room0;
  logic [9:0]  room;
  logic [15:0] asize;
  logic [16:0] block, limit;
  logic        create_ok, alloc_ok, free_ok, walk_last;
  logic [15:0] alloc_addr, free_blk;
  logic [16:0] inuse_dec;
  logic        res_ok;
  logic [15:0] res_addr;

  mpba_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign in_hit   = {1'b0, in_pool_index} < 5'(MAX_POOLS);
  assign in_sel   = in_hit ? in_pool_index[PW-1:0] : '0;
  assign pool_hit = {1'b0, pidx_r} < 5'(MAX_POOLS);
  assign sel      = pool_hit ? pidx_r[PW-1:0] : '0;

  // head link is fetched on acceptance so that it lands in the execute cycle
  mpba_link_mem #(.ARENA_LINKS(ARENA_LINKS)) u_links (
    .clk(clk), .rd_en(accept), .rd_addr(head_r[in_sel]), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  // block geometry: slug padded to alignment with at least the link room in front
  always_comb begin
    sh     = (cfg.align_log2 > ALIGN_MAX) ? ALIGN_MAX : cfg.align_log2;
    a_val  = 9'd1 << sh;
    a_mask = a_val - 9'd1;
    asize  = region_r & ~{7'd0, a_mask};
    room0  = a_val - (slug_r[8:0] & a_mask);
    if (10'(room0) >= LINK_ROOM) begin
      room = 10'(room0);
    end else if (10'(a_val) <= LINK_ROOM) begin
      room = (room0 == a_val) ? LINK_ROOM : 10'(room0) + LINK_ROOM;
    end else begin
      room = 10'(room0) + 10'(a_val);
    end
    block = 17'(slug_r) + 17'(room);
    limit = (cfg.arena_bytes > ARENA_MAX) ? ARENA_MAX : cfg.arena_bytes;
  end

  assign create_ok = pool_hit && !valid_r[sel]
                  && (arena_used_r < limit)
                  && (18'(arena_used_r) + 18'(asize) < 18'(limit))
                  && (block <= 17'(asize));

  assign alloc_ok  = pool_hit && valid_r[sel]
                  && (18'(inuse_r[sel]) + 18'(block_tab_r[sel]) <= 18'(region_tab_r[sel]));
  assign alloc_addr = head_r[sel] + block_tab_r[sel][15:0] - slug_r;

  assign free_ok   = pool_hit && valid_r[sel] && (faddr_r >= start_r[sel])
                  && (18'(faddr_r) <= 18'(start_r[sel])
                      + 18'(region_tab_r[sel] - 17'(slug_tab_r[sel])));
  assign free_blk  = faddr_r - block_tab_r[sel][15:0] + slug_r;
  assign inuse_dec = (inuse_r[sel] >= block_tab_r[sel]) ? inuse_r[sel] - block_tab_r[sel]
                                                        : 17'd0;

  // last block of the chain points back to the region start
  assign walk_last = 18'(walk_off_r) + 18'(walk_block_r) + 18'(walk_block_r)
                   > 18'(walk_size_r);

  // link store write: push on free, chain step during the walk
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk_start_r + walk_off_r[15:0];
    wr_data = walk_last ? walk_start_r
                        : walk_start_r + walk_off_r[15:0] + walk_block_r[15:0];
    if (state_r == S_WALK) begin
      wr_en = 1'b1;
    end else if (state_r == S_EXEC && out_free && cmd_r == CMD_FREE && free_ok) begin
      wr_en   = 1'b1;
      wr_addr = free_blk;
      wr_data = head_r[sel];
    end
  end

  // sequencer and result selection
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    res_ok    = 1'b0;
    res_addr  = 16'd0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          case (cmd_r)
            CMD_CREATE: begin
              if (create_ok) begin
                state_nxt = S_WALK;
              end else begin
                load_out  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            CMD_ALLOC: begin
              load_out  = 1'b1;
              res_ok    = alloc_ok;
              res_addr  = alloc_ok ? alloc_addr : 16'd0;
              state_nxt = S_IDLE;
            end
            CMD_FREE: begin
              load_out  = 1'b1;
              res_ok    = free_ok;
              state_nxt = S_IDLE;
            end
            default: begin
              load_out  = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          res_ok    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      arena_used_r <= 17'd0;
      for (int i = 0; i < MAX_POOLS; i++) valid_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_EXEC && out_free && cmd_r == CMD_CREATE && create_ok) begin
        valid_r[sel] <= 1'b1;
        arena_used_r <= arena_used_r + 17'(asize);
      end
    end
  end

  // payload: item capture, pool descriptors, walk pointers, result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      pidx_r   <= in_pool_index;
      region_r <= in_region_bytes;
      slug_r   <= in_slug_bytes;
      faddr_r  <= in_free_address;
    end
    if (load_out) begin
      out_ok_r   <= res_ok;
      out_addr_r <= res_addr;
    end
    if (state_r == S_WALK) begin
      walk_off_r <= walk_off_r + walk_block_r;
    end
    if (state_r == S_EXEC && out_free) begin
      case (cmd_r)
        CMD_CREATE: begin
          if (create_ok) begin
            start_r[sel]      <= arena_used_r[15:0];
            region_tab_r[sel] <= 17'(asize);
            block_tab_r[sel]  <= block;
            slug_tab_r[sel]   <= slug_r;
            inuse_r[sel]      <= 17'd0;
            head_r[sel]       <= arena_used_r[15:0];
            walk_start_r      <= arena_used_r[15:0];
            walk_off_r        <= 17'd0;
            walk_block_r      <= block;
            walk_size_r       <= 17'(asize);
          end
        end
        CMD_ALLOC: begin
          if (alloc_ok) begin
            head_r[sel]  <= rd_data;
            inuse_r[sel] <= inuse_r[sel] + block_tab_r[sel];
          end
        end
        CMD_FREE: begin
          if (free_ok) begin
            head_r[sel]  <= free_blk;
            inuse_r[sel] <= inuse_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_block_address = out_addr_r;

  // one item at a time: a taken item holds off the next
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("item taken while another is in flight");

  // a rejected command never carries an address
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_addr_r == 16'd0)
    else $error("rejected item with non-zero address");

  // the chain walk stays inside the carved region
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> 18'(walk_off_r) + 18'(walk_block_r) <= 18'(walk_size_r))
    else $error("chain walk past region end");

  // link store is written only on a free or during the walk
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_WALK || (state_r == S_EXEC && cmd_r == CMD_FREE)))
    else $error("stray link store write");

  // bump pointer stays within the byte arena
  a_arena_bound: assert property (@(posedge clk) disable iff (!rst_n)
    arena_used_r < ARENA_MAX)
    else $error("arena bump pointer overflow");

endmodule

>>> design/mpba_link_mem.sv
module mpba_link_mem #(
  parameter int ARENA_LINKS = mpba_pkg::ARENA_LINKS_DEF
) (
  input  logic        clk,
  input  logic        rd_en,
  input  logic [15:0] rd_addr,
  output logic [15:0] rd_data,
  input  logic        wr_en,
  input  logic [15:0] wr_addr,
  input  logic [15:0] wr_data
);
  import mpba_pkg::*;

  localparam int AW = $clog2(ARENA_LINKS);

  logic [15:0] mem [ARENA_LINKS];
  logic [15:0] rdata_r;
  logic        rd_hit_r;
  logic [12:0] rd_idx;
  logic [12:0] wr_idx;
  logic        rd_hit;
  logic        wr_hit;

  // link of the block at byte a sits at entry a >> 3
  assign rd_idx = rd_addr[15:3];
  assign wr_idx = wr_addr[15:3];
  assign rd_hit = 14'(rd_idx) < 14'(ARENA_LINKS);
  assign wr_hit = 14'(wr_idx) < 14'(ARENA_LINKS);

  always_ff @(posedge clk) begin
    if (wr_en && wr_hit) begin
      mem[wr_idx[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r  <= mem[rd_idx[AW-1:0]];
      rd_hit_r <= rd_hit;
    end
  end

  // entries beyond the store read as zero
  assign rd_data = rd_hit_r ? rdata_r : 16'd0;

endmodule

>>> design/mpba_cfg_regs.sv
module mpba_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mpba_pkg::cfg_t cfg
);
  import mpba_pkg::*;

  cfg_t cfg_r;
  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arena_bytes <= ARENA_RESET;
      cfg_r.align_log2  <= ALIGN_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_ARENA: cfg_r.arena_bytes <= pwdata[16:0];
        REG_ALIGN: cfg_r.align_log2  <= pwdata[3:0];
        default:   cfg_r.arena_bytes <= cfg_r.arena_bytes;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ARENA: prdata = {15'd0, cfg_r.arena_bytes};
      REG_ALIGN: prdata = {28'd0, cfg_r.align_log2};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

>>> sim/mpba_checker.sv
module mpba_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_pool_index,
  input  logic [15:0] in_region_bytes,
  input  logic [15:0] in_slug_bytes,
  input  logic [15:0] in_free_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ok,
  input  logic [15:0] out_block_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpba_pkg::*;

  typedef struct {
    logic        ok;
    logic [15:0] addr;
  } grant_t;

  logic [16:0] arena_sz;
  logic [3:0]  align_sh;

  bit          pv [MAX_POOLS_DEF];
  int unsigned p_start [MAX_POOLS_DEF];
  int unsigned p_region [MAX_POOLS_DEF];
  int unsigned p_block [MAX_POOLS_DEF];
  int unsigned p_slug [MAX_POOLS_DEF];
  int unsigned p_used [MAX_POOLS_DEF];
  int unsigned p_head [MAX_POOLS_DEF];
  int unsigned bump;
  logic [15:0] links [ARENA_LINKS_DEF];

  grant_t grants_due[$];

  assign outstanding = grants_due.size();

  function automatic void put_link(int unsigned a, int unsigned v);
    links[(a & 16'hFFFF) >> 3] = v[15:0];
  endfunction

  function automatic bit carve_pool(int unsigned p, int unsigned region, int unsigned slug);
    int unsigned al, lim, asize, room, blk, n;
    al    = 1 << ((align_sh > ALIGN_MAX) ? ALIGN_MAX : align_sh);
    lim   = (arena_sz > ARENA_MAX) ? ARENA_MAX : arena_sz;
    asize = region - (region % al);
    room  = al - (slug % al);
    if (pv[p]) return 0;
    while (room < LINK_ROOM) room += al;
    blk = slug + room;
    if (bump >= lim || bump + asize >= lim) return 0;
    n = asize / blk;
    if (n == 0) return 0;
    pv[p] = 1;
    p_start[p] = bump;
    p_region[p] = asize;
    p_block[p] = blk;
    p_slug[p] = slug;
    p_used[p] = 0;
    p_head[p] = bump;
    for (int unsigned i = 0; i + 1 < n; i++)
      put_link(bump + i * blk, bump + (i + 1) * blk);
    put_link(bump + (n - 1) * blk, bump);
    bump += asize;
    return 1;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] c, int unsigned p, int unsigned region,
                                           int unsigned slug, int unsigned fa);
    grant_t g;
    int unsigned b;
    g.ok = 0;
    g.addr = '0;
    if (p < MAX_POOLS_DEF) begin
      case (cmd_t'(c))
        CMD_CREATE: g.ok = carve_pool(p, region, slug);
        CMD_ALLOC: begin
          if (pv[p] && p_used[p] + p_block[p] <= p_region[p]) begin
            b = p_head[p] + p_block[p] - slug;
            g.addr = b[15:0];
            p_head[p] = links[(p_head[p] & 16'hFFFF) >> 3];
            p_used[p] += p_block[p];
            g.ok = 1;
          end
        end
        CMD_FREE: begin
          if (pv[p] && fa >= p_start[p] && fa <= p_start[p] + (p_region[p] - p_slug[p])) begin
            b = (fa - (p_block[p] - slug)) & 16'hFFFF;
            put_link(b, p_head[p]);
            p_head[p] = b;
            p_used[p] = (p_used[p] >= p_block[p]) ? p_used[p] - p_block[p] : 0;
            g.ok = 1;
          end
        end
        default: g.ok = 0;
      endcase
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      arena_sz <= ARENA_RESET;
      align_sh <= ALIGN_RESET;
      bump = 0;
      errors <= 0;
      grants_due.delete();
      for (int i = 0; i < MAX_POOLS_DEF; i++) begin
        pv[i] = 0; p_start[i] = 0; p_region[i] = 0; p_block[i] = 0;
        p_slug[i] = 0; p_used[i] = 0; p_head[i] = 0;
      end
    end else begin
      // results first: nothing can come back on the edge its item is taken
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected result ok=%0b addr=%h", $time, out_ok, out_block_address);
          errors <= errors + 1;
        end else begin
          want = grants_due.pop_front();
          if (want.ok !== out_ok || want.addr !== out_block_address) begin
            $display("%0t: mismatch expected ok=%0b addr=%h actual ok=%0b addr=%h",
                     $time, want.ok, want.addr, out_ok, out_block_address);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        grants_due.push_back(predict_grant(in_command, in_pool_index, in_region_bytes,
                                           in_slug_bytes, in_free_address));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ARENA) arena_sz <= pwdata[16:0];
        else align_sh <= pwdata[3:0];
      end
    end
  end
endmodule

>>> sim/multi_pool_block_allocator_core_tb.sv
module multi_pool_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpba_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  in_command;
  logic [3:0]  in_pool_index;
  logic [15:0] in_region_bytes, in_slug_bytes, in_free_address;
  logic        out_valid, out_stall, out_ok;
  logic [15:0] out_block_address;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, outstanding;

  // stimulus bookkeeping: slug used at each pool's create, addresses handed out
  logic [15:0] pool_slug_guess [16];
  logic [3:0]  issued_pool[$];
  logic [1:0]  issued_cmd[$];
  logic [3:0]  live_pool[$];
  logic [15:0] live_addr[$];
  bit          no_gaps;
  int          n_items, n_granted;

  multi_pool_block_allocator_core dut (.*);

  mpba_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stall per item, with stretches of none at all
  initial begin
    int k;
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      k = no_gaps ? 0 : $urandom_range(0, 5);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // track granted addresses so that frees mostly hit real blocks
  always @(posedge clk) begin
    logic [3:0] p;
    logic [1:0] c;
    if (rst_n) begin
      if (out_valid && !out_stall && issued_pool.size() > 0) begin
        p = issued_pool.pop_front();
        c = issued_cmd.pop_front();
        if (out_ok) n_granted++;
        if (out_ok && c == CMD_ALLOC) begin
          live_pool.push_back(p);
          live_addr.push_back(out_block_address);
        end
      end
      if (in_valid && !in_stall) begin
        issued_pool.push_back(in_pool_index);
        issued_cmd.push_back(in_command);
      end
    end
  end

  task automatic send_item(logic [1:0] c, logic [3:0] p, logic [15:0] rg,
                           logic [15:0] sl, logic [15:0] fa);
    int k;
    k = no_gaps ? 0 : $urandom_range(0, 5);
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    if (c == CMD_CREATE) pool_slug_guess[p] = sl;
    in_valid        <= 1'b1;
    in_command      <= c;
    in_pool_index   <= p;
    in_region_bytes <= rg;
    in_slug_bytes   <= sl;
    in_free_address <= fa;
    do @(posedge clk); while (!(in_valid && !in_stall));
    n_items++;
  endtask

  task automatic apb_write(logic r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off until every result is back, plus slack
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_items(int count);
    int r, i, p;
    logic [15:0] sl;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 7);
      sl = ($urandom_range(0, 7) == 0) ? 16'($urandom) : pool_slug_guess[p];
      if (r < 8) begin
        if ($urandom_range(0, 3) == 0)
          send_item(CMD_CREATE, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_item(CMD_CREATE, 4'(p), 16'($urandom_range(0, 1500)),
                    16'($urandom_range(0, 120)), 16'($urandom));
      end else if (r < 55) begin
        send_item(CMD_ALLOC, 4'(p), 16'($urandom), sl, 16'($urandom));
      end else if (r < 85 && live_addr.size() > 0) begin
        i = $urandom_range(0, live_addr.size() - 1);
        p = live_pool[i];
        send_item(CMD_FREE, 4'(p), 16'($urandom), pool_slug_guess[p], live_addr[i]);
        live_pool.delete(i);
        live_addr.delete(i);
      end else begin
        // noise: any command, any pool, any field
        send_item(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_CREATE;
    in_pool_index <= '0;
    in_region_bytes <= '0;
    in_slug_bytes <= '0;
    in_free_address <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    no_gaps = 0;
    n_items = 0;
    n_granted = 0;
    foreach (pool_slug_guess[i]) pool_slug_guess[i] = 16'd8;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, alignment 8
    send_item(CMD_CREATE, 4'd0, 16'd256, 16'd8, 16'd0);      // 16 blocks of 16
    send_item(CMD_CREATE, 4'd0, 16'd256, 16'd8, 16'd0);      // already exists
    send_item(CMD_CREATE, 4'd9, 16'd64, 16'd0, 16'd0);       // pool out of range
    send_item(CMD_ALLOC, 4'd15, 16'd0, 16'd0, 16'd0);
    send_item(CMD_ALLOC, 4'd1, 16'd0, 16'd0, 16'd0);         // pool not created
    send_item(CMD_FREE, 4'd1, 16'd0, 16'd0, 16'd0);
    send_item(2'd3, 4'd0, 16'd0, 16'd8, 16'd0);              // unknown command
    send_item(CMD_CREATE, 4'd1, 16'd5, 16'd0, 16'd0);        // region aligns to nothing
    send_item(CMD_CREATE, 4'd1, 16'd16, 16'd9, 16'd0);       // no whole block fits
    send_item(CMD_CREATE, 4'd1, 16'd64, 16'd0, 16'd0);       // 8 blocks of 8
    repeat (9) send_item(CMD_ALLOC, 4'd1, 16'd0, 16'd0, 16'd0);  // last one full
    send_item(CMD_FREE, 4'd1, 16'd0, 16'd0, 16'd264);
    send_item(CMD_FREE, 4'd1, 16'd0, 16'd0, 16'd255);        // below start
    send_item(CMD_FREE, 4'd1, 16'd0, 16'd0, 16'd321);        // past last slug
    send_item(CMD_FREE, 4'd1, 16'd0, 16'd0, 16'd320);        // exactly at the edge
    send_item(CMD_CREATE, 4'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF); // arena overflow
    send_item(CMD_ALLOC, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // address wraps
    drain();

    // phases through the settings, extremes among them
    apb_write(REG_ALIGN, 32'd0);
    apb_write(REG_ARENA, 32'd40000);
    drain();
    random_items(360);
    drain();
    apb_write(REG_ALIGN, 32'd8);
    apb_write(REG_ARENA, 32'h1FFFF);
    drain();
    random_items(360);
    drain();
    apb_write(REG_ALIGN, 32'hF);
    apb_write(REG_ARENA, 32'd1);
    drain();
    random_items(360);
    drain();
    apb_write(REG_ALIGN, 32'd5);
    apb_write(REG_ARENA, 32'd65536);
    drain();
    random_items(360);
    drain();
    apb_write(REG_ALIGN, 32'd3);
    apb_write(REG_ARENA, 32'd60000);
    drain();
    random_items(360);
    drain();

    $display("covered %0d items over six settings, %0d of them granted", n_items, n_granted);
    $display("create, allocate, free and rejects with random gaps and stalls on both sides");
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/mpba_pkg.sv
design/mpba_link_mem.sv
design/mpba_cfg_regs.sv
design/multi_pool_block_allocator_core.sv
sim/mpba_checker.sv
sim/multi_pool_block_allocator_core_tb.sv
